### hw/rtl/framed_packet_receiver_top_defines.svh
// ----------------------------------------------------------------------------
// Framed packet receiver assertion macros
// Shared property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef FRAMED_PACKET_RECEIVER_TOP_DEFINES_SVH
`define FRAMED_PACKET_RECEIVER_TOP_DEFINES_SVH

// Checked on every rising edge outside of reset.
`define FRP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define FRP_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hw/rtl/frp_pkg.sv
// ----------------------------------------------------------------------------
// Framed packet receiver package
// Result record, parser phases, register indexes and frame layout constants.
// ----------------------------------------------------------------------------
`default_nettype none

package frp_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CfgHeadByte    = 2'd0;
  localparam logic [1:0] CfgVersionByte = 2'd1;
  localparam logic [1:0] CfgMaxLen      = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [7:0]  HeadByteReset    = 8'd170;
  localparam logic [7:0]  VersionByteReset = 8'd1;
  localparam logic [15:0] MaxLenReset      = 16'd1024;

  // Frame layout: head, version, two length bytes, five header bytes,
  // two checksum bytes around the payload.
  localparam int unsigned FrameOverhead = 11;
  localparam int unsigned HeaderBytes   = 5;

  // Positions inside the five-byte header.
  localparam logic [15:0] HdrPosSource  = 16'd0;
  localparam logic [15:0] HdrPosTarget  = 16'd1;
  localparam logic [15:0] HdrPosCommand = 16'd2;
  localparam logic [15:0] HdrPosIndexLo = 16'd3;

  // Depth of the queue between parser and output stage.
  localparam int unsigned QueueDepth = 4;

  // Result kinds.
  localparam logic KindPayload = 1'b0;
  localparam logic KindVerdict = 1'b1;

  typedef enum logic [7:0] {
    PhHunt  = 8'b0000_0001,
    PhHead  = 8'b0000_0010,
    PhVer   = 8'b0000_0100,
    PhLenLo = 8'b0000_1000,
    PhHdr   = 8'b0001_0000,
    PhPay   = 8'b0010_0000,
    PhSumLo = 8'b0100_0000,
    PhSumHi = 8'b1000_0000
  } frp_phase_e;

  typedef struct packed {
    logic        result_kind;
    logic        frame_ok;
    logic [7:0]  payload_byte;
    logic [15:0] payload_offset;
    logic [7:0]  source_id;
    logic [7:0]  target_id;
    logic [7:0]  command_code;
    logic [15:0] data_index;
    logic [15:0] payload_len;
  } frp_result_t;

endpackage

`default_nettype wire

### hw/rtl/frp_front.sv
// ----------------------------------------------------------------------------
// Framed packet receiver front end
// Holds the configuration and parses accepted bytes, one byte per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module frp_front #(
  parameter int unsigned FRAME_BUFFER_BYTES = 2048
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [15:0]        cfg_data_i,
  input  wire logic               accept_i,
  input  wire logic [7:0]         rx_byte_i,
  output logic                    push_o,
  output frp_pkg::frp_result_t    rec_o
);
  import frp_pkg::*;

  localparam logic [16:0] BufLimit = 17'(FRAME_BUFFER_BYTES);

  logic [7:0]  head_byte_q;
  logic [7:0]  version_byte_q;
  logic [15:0] max_len_q;

  frp_phase_e  phase_q, phase_d;
  logic [15:0] body_count_q, body_count_d;
  logic [15:0] length_q, length_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  src_q, src_d;
  logic [7:0]  tgt_q, tgt_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [15:0] index_q, index_d;
  logic [7:0]  sum_lo_q, sum_lo_d;

  logic [15:0] count_inc;
  logic [15:0] sum_add;
  logic [15:0] new_len;
  logic [16:0] frame_size;
  logic [15:0] expect_sum;
  logic        sum_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_byte_q    <= HeadByteReset;
      version_byte_q <= VersionByteReset;
      max_len_q      <= MaxLenReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgHeadByte:    head_byte_q    <= cfg_data_i[7:0];
        CfgVersionByte: version_byte_q <= cfg_data_i[7:0];
        CfgMaxLen:      max_len_q      <= cfg_data_i;
        default:        ;
      endcase
    end
  end

  assign count_inc  = body_count_q + 16'd1;
  assign sum_add    = sum_q + {8'd0, rx_byte_i};
  assign new_len    = {rx_byte_i, length_q[7:0]};
  assign frame_size = {1'b0, new_len} + 17'(FrameOverhead);
  assign expect_sum = ~sum_q;
  assign sum_ok     = (expect_sum[7:0] == sum_lo_q) && (expect_sum[15:8] == rx_byte_i);

  always_comb begin
    phase_d      = phase_q;
    body_count_d = body_count_q;
    length_d     = length_q;
    sum_d        = sum_q;
    src_d        = src_q;
    tgt_d        = tgt_q;
    cmd_d        = cmd_q;
    index_d      = index_q;
    sum_lo_d     = sum_lo_q;
    push_o       = 1'b0;

    rec_o.result_kind    = KindPayload;
    rec_o.frame_ok       = 1'b0;
    rec_o.payload_byte   = 8'd0;
    rec_o.payload_offset = 16'd0;
    rec_o.source_id      = src_q;
    rec_o.target_id      = tgt_q;
    rec_o.command_code   = cmd_q;
    rec_o.data_index     = index_q;
    rec_o.payload_len    = length_q;

    case (phase_q)
      PhHunt: begin
        if (rx_byte_i == head_byte_q) begin
          phase_d      = PhHead;
          body_count_d = 16'd0;
          length_d     = 16'd0;
          sum_d        = 16'd0;
        end
      end
      PhHead: begin
        if (rx_byte_i == version_byte_q) begin
          phase_d = PhVer;
        end else if (rx_byte_i == head_byte_q) begin
          phase_d      = PhHead;
          body_count_d = 16'd0;
          length_d     = 16'd0;
          sum_d        = 16'd0;
        end else begin
          phase_d = PhHunt;
        end
      end
      PhVer: begin
        length_d = {8'd0, rx_byte_i};
        sum_d    = {8'd0, rx_byte_i};
        phase_d  = PhLenLo;
      end
      PhLenLo: begin
        length_d = new_len;
        sum_d    = sum_add;
        if ((new_len > max_len_q) || (frame_size > BufLimit)) begin
          phase_d = PhHunt;
        end else begin
          phase_d      = PhHdr;
          body_count_d = 16'd0;
        end
      end
      PhHdr: begin
        sum_d = sum_add;
        case (body_count_q)
          HdrPosSource:  src_d   = rx_byte_i;
          HdrPosTarget:  tgt_d   = rx_byte_i;
          HdrPosCommand: cmd_d   = rx_byte_i;
          HdrPosIndexLo: index_d = {8'd0, rx_byte_i};
          default:       index_d = {rx_byte_i, index_q[7:0]};
        endcase
        body_count_d = count_inc;
        if (count_inc >= 16'(HeaderBytes)) begin
          body_count_d = 16'd0;
          phase_d      = (length_q != 16'd0) ? PhPay : PhSumLo;
        end
      end
      PhPay: begin
        sum_d                = sum_add;
        push_o               = accept_i;
        rec_o.payload_byte   = rx_byte_i;
        rec_o.payload_offset = body_count_q;
        body_count_d         = count_inc;
        if (count_inc >= length_q) begin
          phase_d = PhSumLo;
        end
      end
      PhSumLo: begin
        sum_lo_d = rx_byte_i;
        phase_d  = PhSumHi;
      end
      PhSumHi: begin
        push_o            = accept_i;
        rec_o.result_kind = KindVerdict;
        rec_o.frame_ok    = sum_ok;
        if (!sum_ok && (rx_byte_i == head_byte_q)) begin
          phase_d      = PhHead;
          body_count_d = 16'd0;
          length_d     = 16'd0;
          sum_d        = 16'd0;
        end else begin
          phase_d = PhHunt;
        end
      end
      default: begin
        phase_d = PhHunt;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhHunt;
      body_count_q <= 16'd0;
      length_q     <= 16'd0;
      sum_q        <= 16'd0;
      src_q        <= 8'd0;
      tgt_q        <= 8'd0;
      cmd_q        <= 8'd0;
      index_q      <= 16'd0;
      sum_lo_q     <= 8'd0;
    end else if (accept_i) begin
      phase_q      <= phase_d;
      body_count_q <= body_count_d;
      length_q     <= length_d;
      sum_q        <= sum_d;
      src_q        <= src_d;
      tgt_q        <= tgt_d;
      cmd_q        <= cmd_d;
      index_q      <= index_d;
      sum_lo_q     <= sum_lo_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/frp_queue.sv
// ----------------------------------------------------------------------------
// Framed packet receiver result queue
// Small first-in first-out buffer between the parser and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module frp_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire frp_pkg::frp_result_t push_data_i,
  output logic                      full_o,
  input  wire logic                 pop_i,
  output logic                      valid_o,
  output frp_pkg::frp_result_t      pop_data_o
);
  import frp_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);
  localparam logic [PtrW-1:0] PtrOne  = PtrW'(1);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  frp_result_t     mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o     = (count_q == FullCnt);
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrOne;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrOne;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + CntOne;
        2'b01:   count_q <= count_q - CntOne;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/frp_back.sv
// ----------------------------------------------------------------------------
// Framed packet receiver output stage
// Registers one result item and hands it to the downstream side.
// ----------------------------------------------------------------------------
`default_nettype none

module frp_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 queue_valid_i,
  input  wire frp_pkg::frp_result_t queue_data_i,
  output logic                      pop_o,
  input  wire logic                 out_stall_i,
  output logic                      out_valid_o,
  output frp_pkg::frp_result_t      out_rec_o
);
  import frp_pkg::*;

  logic        out_valid_q, out_valid_d;
  frp_result_t out_rec_q;

  // The register takes a new item when it is empty or its item leaves now.
  assign pop_o       = queue_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_d = pop_o || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_rec_q <= queue_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rec_o   = out_rec_q;

endmodule

`default_nettype wire

### hw/rtl/framed_packet_receiver_top.sv
// ----------------------------------------------------------------------------
// Framed packet receiver, byte-stream frame parser with 16-bit complement sum
// Throughput: one received byte per cycle while the result queue has room.
// Result path: an item goes through the queue, then the output register.
// Reset: asynchronous, active low; parser hunts for a head byte, queue empty.
// ----------------------------------------------------------------------------
`default_nettype none

module framed_packet_receiver_top #(
  // Size of the frame buffer that a whole frame, overhead included, must fit.
  parameter int unsigned FRAME_BUFFER_BYTES = 2048
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write port.
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  // Received byte stream.
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  // Result items.
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             result_kind_o,
  output logic             frame_ok_o,
  output logic [7:0]       payload_byte_o,
  output logic [15:0]      payload_offset_o,
  output logic [7:0]       source_id_o,
  output logic [7:0]       target_id_o,
  output logic [7:0]       command_code_o,
  output logic [15:0]      data_index_o,
  output logic [15:0]      payload_len_o
);
  import frp_pkg::*;

  // The design is split into a parser front end, a short result queue and an
  // output register. The parser steps once for every accepted byte and may
  // produce one result item; that item is pushed into the queue in the same
  // cycle. The output stage drains the queue into a register that holds the
  // item steady while the downstream side stalls.

  logic        accept;
  logic        push;
  frp_result_t push_rec;
  logic        queue_full;
  logic        queue_valid;
  frp_result_t queue_rec;
  logic        pop;
  frp_result_t out_rec;

  // Bytes are refused only while the queue has no room. The stall comes from
  // a registered count, so it never depends on the incoming valid.
  assign in_stall_o = queue_full;
  assign accept     = in_valid_i && !in_stall_o;

  frp_front #(
    .FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .push_o    (push),
    .rec_o     (push_rec)
  );

  // The queue decouples the parser from downstream back pressure, so a full
  // output register does not stop the byte stream until the queue fills too.
  frp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_rec),
    .full_o     (queue_full),
    .pop_i      (pop),
    .valid_o    (queue_valid),
    .pop_data_o (queue_rec)
  );

  frp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .queue_valid_i(queue_valid),
    .queue_data_i (queue_rec),
    .pop_o        (pop),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_rec_o    (out_rec)
  );

  // Header fields and the length come with both kinds of result item; the
  // byte and offset are zero in a verdict and the verdict flag is zero in a
  // payload item.
  assign result_kind_o    = out_rec.result_kind;
  assign frame_ok_o       = out_rec.frame_ok;
  assign payload_byte_o   = out_rec.payload_byte;
  assign payload_offset_o = out_rec.payload_offset;
  assign source_id_o      = out_rec.source_id;
  assign target_id_o      = out_rec.target_id;
  assign command_code_o   = out_rec.command_code;
  assign data_index_o     = out_rec.data_index;
  assign payload_len_o    = out_rec.payload_len;

endmodule

`default_nettype wire

### hw/rtl/frp_checker.sv
// ----------------------------------------------------------------------------
// Framed packet receiver port checker
// Watches the top-level ports for output protocol and result consistency.
// ----------------------------------------------------------------------------
`default_nettype none

`include "framed_packet_receiver_top_defines.svh"

module frp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        result_kind_o,
  input wire logic        frame_ok_o,
  input wire logic [7:0]  payload_byte_o,
  input wire logic [15:0] payload_offset_o,
  input wire logic [15:0] data_index_o,
  input wire logic [15:0] payload_len_o
);

  // Under reset the output register is empty.
  `FRP_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |=> !out_valid_o, "result offered in reset")

  `FRP_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(result_kind_o) && $stable(frame_ok_o) && $stable(payload_byte_o) && $stable(payload_offset_o) && $stable(data_index_o) && $stable(payload_len_o), "stalled result changed")

  `FRP_ASSERT(a_verdict_clean, out_valid_o && result_kind_o |-> payload_byte_o == 8'd0 && payload_offset_o == 16'd0, "verdict carries payload data")

  `FRP_ASSERT(a_payload_no_ok, out_valid_o && !result_kind_o |-> !frame_ok_o, "payload item flagged ok")

  `FRP_ASSERT(a_offset_in_len, out_valid_o && !result_kind_o |-> payload_offset_o < payload_len_o, "payload offset beyond length")

endmodule

bind framed_packet_receiver_top frp_checker u_frp_checker (.*);

`default_nettype wire
